>>> hdl/multichannel_biquad_lowpass_defines.svh
// Assertion macros shared by the multichannel biquad low-pass block.
// Files that check their own logic include this header by its bare name.
// The macros expect clk_i and rst_ni in the including module.
`ifndef MULTICHANNEL_BIQUAD_LOWPASS_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_LOWPASS_DEFINES_SVH

`ifndef SYNTHESIS
`define MBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MBL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MBL_ASSERT(lbl, prop, msg)
`define MBL_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> hdl/mbl_pkg.sv
// Types, constants and helper functions for the multichannel biquad low-pass block.
// Used by the stream interfaces, the register file, the controller and the datapath.
package mbl_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 18;
  localparam int STATE_W    = 34;
  localparam int COUNT_W    = 4;
  localparam int CHAN_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = COEF_W + STATE_W;
  localparam int Y16_W      = 43;
  localparam int ACC_W      = 56;
  localparam int RND_W      = 40;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_COUNT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [COUNT_W-1:0]       count;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_ADD_Y,
    OP_ADD_S2,
    OP_LOAD_B2,
    OP_SUB_A1,
    OP_STORE_S1,
    OP_STORE_S2
  } op_e;

  typedef enum logic [2:0] {
    SEL_B0,
    SEL_B1,
    SEL_B2,
    SEL_A1,
    SEL_A2
  } mul_sel_e;

  typedef struct packed {
    op_e      op;
    logic     mul_en;
    mul_sel_e sel;
  } cmd_t;

  function automatic logic signed [STATE_W-1:0] sat34(input logic signed [RND_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v[RND_W-1] && !(&v[RND_W-2:STATE_W-1])) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else if (!v[RND_W-1] && (|v[RND_W-2:STATE_W-1])) begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [RND_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v[RND_W-1] && !(&v[RND_W-2:SAMPLE_W-1])) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else if (!v[RND_W-1] && (|v[RND_W-2:SAMPLE_W-1])) begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/mbl_in_if.sv
// Input stream interface: one signed 24-bit sample per item.
// Depends on mbl_pkg for the sample width.
interface mbl_in_if;
  import mbl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

>>> hdl/mbl_out_if.sv
// Output stream interface: one filtered sample and its channel index per item.
// Depends on mbl_pkg for the field widths.
interface mbl_out_if;
  import mbl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [CHAN_W-1:0]          channel;

  modport source (output valid, output sample_out, output channel, input ready);
  modport sink (input valid, input sample_out, input channel, output ready);
endinterface

>>> hdl/mbl_cfg.sv
// Configuration register file: five filter coefficients and the channel count.
// Depends on mbl_pkg for the register indexes and the cfg_t bundle.
module mbl_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mbl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mbl_pkg::COEF_W-1:0]     cfg_data_i,
  output mbl_pkg::cfg_t                  cfg_o
);
  import mbl_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b0    <= '0;
      cfg_q.b1    <= '0;
      cfg_q.b2    <= '0;
      cfg_q.a1    <= '0;
      cfg_q.a2    <= '0;
      cfg_q.count <= COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_B0:    cfg_q.b0    <= cfg_data_i;
        REG_B1:    cfg_q.b1    <= cfg_data_i;
        REG_B2:    cfg_q.b2    <= cfg_data_i;
        REG_A1:    cfg_q.a1    <= cfg_data_i;
        REG_A2:    cfg_q.a2    <= cfg_data_i;
        REG_COUNT: cfg_q.count <= cfg_data_i[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

>>> hdl/mbl_ctrl.sv
// Sequencer for the biquad datapath and handshake control for both streams.
// Depends on mbl_pkg for the command bundle and on the assertion macro header.
`include "multichannel_biquad_lowpass_defines.svh"

module mbl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output mbl_pkg::cmd_t cmd_o
);
  import mbl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_B0,
    S_B1,
    S_B2,
    S_A1,
    S_A2,
    S_WR1,
    S_WR2
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NOP;
    cmd_o.mul_en  = 1'b0;
    cmd_o.sel     = SEL_B0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_B0;
        end
      end
      S_B0: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.sel    = SEL_B0;
        state_d      = S_B1;
      end
      S_B1: begin
        cmd_o.op     = OP_ADD_Y;
        cmd_o.mul_en = 1'b1;
        cmd_o.sel    = SEL_B1;
        state_d      = S_B2;
      end
      S_B2: begin
        cmd_o.op     = OP_ADD_S2;
        cmd_o.mul_en = 1'b1;
        cmd_o.sel    = SEL_B2;
        state_d      = S_A1;
      end
      S_A1: begin
        cmd_o.op     = OP_LOAD_B2;
        cmd_o.mul_en = 1'b1;
        cmd_o.sel    = SEL_A1;
        state_d      = S_A2;
      end
      S_A2: begin
        cmd_o.op     = OP_SUB_A1;
        cmd_o.mul_en = 1'b1;
        cmd_o.sel    = SEL_A2;
        state_d      = S_WR1;
      end
      S_WR1: begin
        cmd_o.op = OP_STORE_S1;
        state_d  = S_WR2;
      end
      S_WR2: begin
        if (slot_free) begin
          cmd_o.op = OP_STORE_S2;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_STORE_S2) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MBL_ASSERT(a_accept_starts, (in_valid_i && in_ready_o) |=> (state_q == S_B0), "Accepted item did not start the sequence.")
  `MBL_ASSERT(a_store_sets_valid, (cmd_o.op == OP_STORE_S2) |=> out_valid_q, "Stored result was not presented.")
  `MBL_ASSERT_NEVER(a_no_overwrite, out_valid_q && !out_ready_i && (cmd_o.op == OP_STORE_S2), "Pending result overwritten.")
  `MBL_ASSERT(a_valid_from_store, $rose(out_valid_q) |-> $past(state_q == S_WR2), "Result valid without a store.")
endmodule

>>> hdl/mbl_dp.sv
// Biquad datapath: channel position, per-channel delay words, one shared multiplier,
// accumulators and the output register. Depends on mbl_pkg and is driven by mbl_ctrl.
module mbl_dp #(
  parameter int MAX_CHANNELS = mbl_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mbl_pkg::cmd_t                       cmd_i,
  input  mbl_pkg::cfg_t                       cfg_i,
  input  logic signed [mbl_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic signed [mbl_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [mbl_pkg::CHAN_W-1:0]          channel_o
);
  import mbl_pkg::*;

  localparam int PW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CLW = ($clog2(MAX_CHANNELS + 1) > COUNT_W) ? $clog2(MAX_CHANNELS + 1) : COUNT_W;
  localparam int CW  = CLW + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHANNELS);

  logic [PW-1:0]               pos_q;
  logic [PW-1:0]               ch_q;
  logic signed [SAMPLE_W-1:0]  x_q;
  logic signed [STATE_W-1:0]   first_q [MAX_CHANNELS];
  logic signed [STATE_W-1:0]   second_q [MAX_CHANNELS];
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [Y16_W-1:0]     y16_q;
  logic signed [STATE_W-1:0]   yf_q;
  logic signed [SAMPLE_W-1:0]  yo_q;
  logic signed [ACC_W-1:0]     acc1_q;
  logic signed [ACC_W-1:0]     acc2_q;
  logic signed [SAMPLE_W-1:0]  sample_out_q;
  logic [CHAN_W-1:0]           channel_q;

  logic [CW-1:0]               cnt;
  logic [CW-1:0]               n_eff;
  logic [CW-1:0]               pos_ext;
  logic [CW-1:0]               ch_sel;
  logic [CW-1:0]               ch_inc;
  logic [CW-1:0]               pos_next;
  logic signed [COEF_W-1:0]    mul_a;
  logic signed [STATE_W-1:0]   mul_b;
  logic signed [STATE_W-1:0]   x_ext;
  logic signed [STATE_W-1:0]   s1_rd;
  logic signed [STATE_W-1:0]   s2_rd;
  logic signed [Y16_W-1:0]     y16_sum;
  logic signed [Y16_W-1:0]     y_rnd8;
  logic signed [Y16_W-1:0]     y_rnd16;
  logic signed [ACC_W-1:0]     prod_ext;
  logic signed [ACC_W-1:0]     prod_sh8;
  logic signed [ACC_W-1:0]     acc1_rnd;
  logic signed [ACC_W-1:0]     acc2_rnd;

  always_comb begin
    cnt = {{(CW-COUNT_W){1'b0}}, cfg_i.count};
    if (cnt == '0) begin
      n_eff = CW'(1);
    end else if (cnt > MAX_CNT) begin
      n_eff = MAX_CNT;
    end else begin
      n_eff = cnt;
    end
    pos_ext  = CW'(pos_q);
    ch_sel   = (pos_ext >= n_eff) ? '0 : pos_ext;
    ch_inc   = ch_sel + CW'(1);
    pos_next = (ch_inc >= n_eff) ? '0 : ch_inc;
  end

  assign x_ext = {{(STATE_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
  assign s1_rd = first_q[ch_q];
  assign s2_rd = second_q[ch_q];

  always_comb begin
    mul_b = x_ext;
    case (cmd_i.sel)
      SEL_B0:  mul_a = cfg_i.b0;
      SEL_B1:  mul_a = cfg_i.b1;
      SEL_B2:  mul_a = cfg_i.b2;
      SEL_A1: begin
        mul_a = cfg_i.a1;
        mul_b = yf_q;
      end
      SEL_A2: begin
        mul_a = cfg_i.a2;
        mul_b = yf_q;
      end
      default: mul_a = cfg_i.b0;
    endcase
  end

  // Sample products fit in 42 bits, so the shifted copy keeps the low bits of the product.
  assign y16_sum  = {s1_rd[STATE_W-1], s1_rd, 8'b0} + prod_q[Y16_W-1:0];
  assign y_rnd8   = y16_q + Y16_W'(128);
  assign y_rnd16  = y16_q + Y16_W'(32768);
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign prod_sh8 = {prod_q[ACC_W-9:0], 8'b0};
  assign acc1_rnd = acc1_q + ACC_W'(32768);
  assign acc2_rnd = acc2_q + ACC_W'(32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        first_q[i]  <= '0;
        second_q[i] <= '0;
      end
    end else begin
      case (cmd_i.op)
        OP_LOAD:     pos_q <= pos_next[PW-1:0];
        OP_STORE_S1: first_q[ch_q] <= sat34(acc1_rnd[ACC_W-1:16]);
        OP_STORE_S2: second_q[ch_q] <= sat34(acc2_rnd[ACC_W-1:16]);
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        x_q  <= sample_in_i;
        ch_q <= ch_sel[PW-1:0];
      end
      OP_ADD_Y: y16_q <= y16_sum;
      OP_ADD_S2: begin
        yf_q   <= sat34({{(RND_W-(Y16_W-8)){y_rnd8[Y16_W-1]}}, y_rnd8[Y16_W-1:8]});
        yo_q   <= sat24({{(RND_W-(Y16_W-16)){y_rnd16[Y16_W-1]}}, y_rnd16[Y16_W-1:16]});
        acc1_q <= {{(ACC_W-STATE_W-16){s2_rd[STATE_W-1]}}, s2_rd, 16'b0} + prod_sh8;
      end
      OP_LOAD_B2:  acc2_q <= prod_sh8;
      OP_SUB_A1:   acc1_q <= acc1_q - prod_ext;
      OP_STORE_S1: acc2_q <= acc2_q - prod_ext;
      OP_STORE_S2: begin
        sample_out_q <= yo_q;
        channel_q    <= CHAN_W'(ch_q);
      end
      default: ;
    endcase
  end

  assign sample_out_o = sample_out_q;
  assign channel_o    = channel_q;
endmodule

>>> hdl/multichannel_biquad_lowpass.sv
// Multichannel biquad low-pass filter in transposed direct form II, fixed point.
// Each sample goes through one sequencer pass: the idle state that accepts it and seven
// steps that share a single 18 x 34 multiplier for the five products of the section.
// A new item is taken only when the sequencer is idle, so a sample is not accepted
// before the previous result is stored. A finished item waits in the output register
// while the next one is accepted; if that register is still full when the next result
// is due, the sequencer holds in its last step. Samples are assigned to channels in turn
// up to the configured channel count. Registers are to be written by the user only while
// the block is idle; the block itself does not enforce it. New coefficients apply from the next sample.
// Depends on mbl_pkg, the stream interfaces, mbl_cfg, mbl_ctrl and mbl_dp.
module multichannel_biquad_lowpass #(
  parameter int MAX_CHANNELS = mbl_pkg::MAX_CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mbl_in_if.sink                         in_if,
  mbl_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [mbl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mbl_pkg::COEF_W-1:0]     cfg_data_i
);
  import mbl_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  mbl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .cmd_o       (cmd)
  );

  mbl_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .sample_in_i  (in_if.sample_in),
    .sample_out_o (out_if.sample_out),
    .channel_o    (out_if.channel)
  );
endmodule

>>> tb/sv/multichannel_biquad_lowpass_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multichannel biquad low-pass filter.
// Drives random interleaved samples and register settings, predicts every filtered sample.
// Depends on mbl_pkg, the stream interfaces mbl_in_if and mbl_out_if, and the block itself.
module multichannel_biquad_lowpass_test;
  import mbl_pkg::*;

  localparam int LANES         = MAX_CHANNELS_DEF;
  localparam int ITEM_TARGET   = 1150;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint STATE_HI  = (longint'(1) <<< (STATE_W - 1)) - 1;
  localparam longint STATE_LO  = -(longint'(1) <<< (STATE_W - 1));
  localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_LO = -(longint'(1) <<< (SAMPLE_W - 1));

  localparam logic [COEF_W-1:0]   COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam logic [COEF_W-1:0]   COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] PEAK_POS = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] PEAK_NEG = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
  } filtered_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [COEF_W-1:0]    cfg_data_i;

  mbl_in_if  in_ch ();
  mbl_out_if out_ch ();

  multichannel_biquad_lowpass dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Predicted register contents and per-channel delay words.
  logic signed [COEF_W-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [COUNT_W-1:0]        count_q;
  logic signed [STATE_W-1:0] z1_q [LANES];
  logic signed [STATE_W-1:0] z2_q [LANES];
  int                        next_lane;

  logic signed [SAMPLE_W-1:0] pending_samples [$];
  filtered_t                  expected_out [$];

  logic in_taken, out_taken;
  int   in_wait, out_wait, hold_left;
  bit   in_burst, out_burst, long_hold_req;
  int   errors, cycles, sent;

  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic filtered_t filter_sample(input logic signed [SAMPLE_W-1:0] x_in);
    int        lanes;
    int        lane;
    longint    x, y16, yf, acc;
    filtered_t r;
    lanes = (count_q == 0) ? 1 : ((count_q > LANES) ? LANES : int'(count_q));
    lane  = (next_lane >= lanes) ? 0 : next_lane;
    x     = x_in;
    y16   = longint'(z1_q[lane]) * 256 + longint'(b0_q) * x;
    yf    = clip(round_half_up(y16, 8), STATE_LO, STATE_HI);
    acc   = longint'(z2_q[lane]) * 65536 + longint'(b1_q) * x * 256 - longint'(a1_q) * yf;
    z1_q[lane] = clip(round_half_up(acc, 16), STATE_LO, STATE_HI);
    acc   = longint'(b2_q) * x * 256 - longint'(a2_q) * yf;
    z2_q[lane] = clip(round_half_up(acc, 16), STATE_LO, STATE_HI);
    r.sample  = clip(round_half_up(y16, 16), SAMPLE_LO, SAMPLE_HI);
    r.channel = lane[CHAN_W-1:0];
    next_lane = (lane + 1 >= lanes) ? 0 : lane + 1;
    return r;
  endfunction

  // Bursts without any idling alternate with stretches of random gaps.
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 24) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, 9));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    logic [SAMPLE_W-1:0] r;
    r = SAMPLE_W'($urandom());
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: r = PEAK_POS;
          1: r = PEAK_NEG;
          2: r = '0;
          default: r = '1;
        endcase
      end
      1: r = SAMPLE_W'(int'($urandom_range(0, 2047)) - 1024);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] any_coef();
    case ($urandom_range(0, 7))
      0: return COEF_MAX;
      1: return COEF_MIN;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  // Driver: a new item goes out once the previous one was taken and its gap has passed.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_ch.valid || in_taken)) begin
      if (in_wait > 0) begin
        in_wait--;
        in_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_ch.sample_in <= pending_samples.pop_front();
        in_ch.valid     <= 1'b1;
        in_wait = draw_gap(in_burst);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls for a random gap after each item outside bursts, and for a long stretch on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) out_wait = draw_gap(out_burst);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each accepted sample and checks each accepted result.
  always @(posedge clk_i) begin : monitor
    filtered_t want;
    in_taken  <= rst_ni && in_ch.valid && in_ch.ready;
    out_taken <= rst_ni && out_ch.valid && out_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      expected_out.push_back(filter_sample(in_ch.sample_in));
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_out.size() == 0) begin
        errors++;
        $error("unexpected item: sample_out %0d, channel %0d",
               out_ch.sample_out, out_ch.channel);
      end else begin
        want = expected_out.pop_front();
        if (out_ch.sample_out !== want.sample) begin
          errors++;
          $error("sample_out: expected %0d, got %0d", want.sample, out_ch.sample_out);
        end
        if (out_ch.channel !== want.channel) begin
          errors++;
          $error("channel: expected %0d, got %0d", want.channel, out_ch.channel);
        end
      end
    end
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_B0:    b0_q = value;
      REG_B1:    b1_q = value;
      REG_B2:    b2_q = value;
      REG_A1:    a1_q = value;
      REG_A2:    a2_q = value;
      REG_COUNT: count_q = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] lanes);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_COUNT, lanes);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_samples.size() != 0 || in_ch.valid || expected_out.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int phase;
    int n_items;
    int a1v, a2v, b0v;
    logic [COEF_W-1:0] lanes;

    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready    = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_taken        = 1'b0;
    out_taken       = 1'b0;
    {b0_q, b1_q, b2_q, a1_q, a2_q} = '0;
    count_q   = COUNT_RESET;
    next_lane = 0;
    for (int i = 0; i < LANES; i++) begin
      z1_q[i] = '0;
      z2_q[i] = '0;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: all coefficients zero, two channels.
    pending_samples.push_back(PEAK_POS);
    pending_samples.push_back(PEAK_NEG);
    wait_idle();

    // Extreme coefficients drive both the output and the delay words into saturation.
    set_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_W'(3));
    pending_samples.push_back(PEAK_POS);
    pending_samples.push_back(PEAK_NEG);
    pending_samples.push_back(PEAK_POS);
    pending_samples.push_back(PEAK_NEG);
    pending_samples.push_back('0);
    pending_samples.push_back('1);
    pending_samples.push_back(SAMPLE_W'(1));
    wait_idle();

    // A channel count of zero acts as one channel.
    set_filter(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_W'(0));
    pending_samples.push_back(PEAK_NEG);
    pending_samples.push_back(PEAK_POS);
    pending_samples.push_back('1);
    wait_idle();

    // A count above the channel limit acts as the limit; writes to unused indexes do nothing.
    write_reg(REG_COUNT, COEF_W'(15));
    write_reg(REG_SPARE_LO, COEF_MAX);
    write_reg(REG_SPARE_HI, COEF_MIN);
    repeat (6) pending_samples.push_back(draw_sample());
    wait_idle();

    // Shrinking the count below the current position sends the next sample to channel 0.
    write_reg(REG_COUNT, COEF_W'(2));
    repeat (2) pending_samples.push_back(draw_sample());
    wait_idle();

    phase = 0;
    sent  = 0;
    while (sent < ITEM_TARGET) begin
      lanes = ($urandom_range(0, 3) == 0) ? COEF_W'($urandom_range(0, 15))
                                          : COEF_W'($urandom_range(1, 8));
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, COEF_W'($urandom()));
      end
      if ($urandom_range(0, 3) == 0) begin
        set_filter(any_coef(), any_coef(), any_coef(), any_coef(), any_coef(), lanes);
      end else begin
        a2v = $urandom_range(0, 60000);
        a1v = -int'($urandom_range(0, 65535 + a2v));
        b0v = $urandom_range(0, 16000);
        set_filter(COEF_W'(b0v), COEF_W'(2 * b0v), COEF_W'(b0v),
                   COEF_W'(a1v), COEF_W'(a2v), lanes);
      end
      n_items = $urandom_range(30, 110);
      if (phase == 2) begin
        @(posedge clk_i);
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < n_items; i++) begin
        // Halfway through one phase the sender holds back until all results are in.
        if (phase == 5 && i == n_items / 2) wait_idle();
        pending_samples.push_back(draw_sample());
      end
      sent += n_items;
      wait_idle();
      phase++;
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
